FILE: design/auc_pkg.sv
// Shared types and constants of the audio unit converter.
package auc_pkg;

  // Default width of the amount and of the converted result.
  localparam int AMOUNT_WIDTH_DEF = 32;

  // Widths fixed by the register map.
  localparam int RATE_W     = 20;
  localparam int FIELD16_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Codec block size in the source unit is below 65535 * 1000.
  localparam int BLK_W = 26;

  // Scale factors and divisors reach 16 x 20 bits.
  localparam int SCALE_W = 36;

  localparam int MS_PER_S = 1000;

  // Conversion modes.
  localparam logic [1:0] MODE_WAVE  = 2'd1;
  localparam logic [1:0] MODE_CODEC = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CONV_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ALIGN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_BYTES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SAMPLES = 3'd4;

  // Units of an amount.
  typedef enum logic [1:0] {
    U_MS  = 2'd0,
    U_SMP = 2'd1,
    U_BYT = 2'd2,
    U_PKT = 2'd3
  } unit_e;

  // Item control carried alongside the data through the first two divider chains.
  typedef struct packed {
    unit_e src;
    unit_e dst;
    logic  err;
  } ctl_t;

  // Result flags carried through the final divider chain.
  typedef struct packed {
    logic err;
    logic ovf;
  } flags_t;

endpackage

FILE: design/audio_unit_converter.sv
// Top level of the audio unit converter: config registers, divider chains and scaling.
//
// Each input word converts an amount between milliseconds, samples, bytes and codec
// packets and gives one output word; a new word is taken in every cycle while the
// parking register is empty. The pipeline holds three division chains of one cell
// per quotient bit: 26 cells for the codec block size in the source unit, AMOUNT_WIDTH
// cells for rounding up to a whole block and AMOUNT_WIDTH cells for the final scaled
// quotient, plus entry, round-up, two multiply and output stages. A finished word
// that finds the output stalled is parked in a second output register; the whole
// pipeline holds only while that register is full, so the input ready comes from a
// register and not from the output ready. Write the configuration only while no
// word is in flight; the config channel is always ready.
module audio_unit_converter #(
  parameter int AMOUNT_WIDTH = auc_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // Input words: src_unit [1:0], dst_unit [3:2], amount above, zero padded.
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  logic [((AMOUNT_WIDTH+4+7)/8)*8-1:0]      s_axis_tdata_i,
  // Output words: converted, then overflowed, then div_error, zero padded.
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  output logic [((AMOUNT_WIDTH+2+7)/8)*8-1:0]      m_axis_tdata_o,
  // Register writes.
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [auc_pkg::CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [auc_pkg::CFG_DATA_W-1:0]           cfg_data_i
);

  localparam int W      = AMOUNT_WIDTH;
  localparam int OUT_TW = ((W + 2 + 7) / 8) * 8;
  localparam int BLKW   = auc_pkg::BLK_W;
  localparam int SRW    = auc_pkg::RATE_W;
  localparam int FW     = auc_pkg::FIELD16_W;
  localparam int MW     = auc_pkg::SCALE_W;
  localparam int NRW    = ((W > BLKW) ? W : BLKW) + 1;
  localparam int PW     = NRW + MW;
  localparam int HW     = PW - W;
  localparam int LH     = (NRW + 1) / 2;
  localparam int MH     = MW / 2;
  localparam int CTLW   = $bits(auc_pkg::ctl_t);
  localparam int FLW    = $bits(auc_pkg::flags_t);

  // Configuration registers.
  logic [1:0]     mode_q;
  logic [FW-1:0]  ba_q;
  logic [SRW-1:0] sr_q;
  logic [FW-1:0]  pb_q;
  logic [FW-1:0]  bs_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      ba_q   <= '0;
      sr_q   <= '0;
      pb_q   <= '0;
      bs_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        auc_pkg::REG_CONV_MODE:     mode_q <= cfg_data_i[1:0];
        auc_pkg::REG_BLOCK_ALIGN:   ba_q   <= cfg_data_i[FW-1:0];
        auc_pkg::REG_SAMPLE_RATE:   sr_q   <= cfg_data_i[SRW-1:0];
        auc_pkg::REG_PACKET_BYTES:  pb_q   <= cfg_data_i[FW-1:0];
        auc_pkg::REG_BLOCK_SAMPLES: bs_q   <= cfg_data_i[FW-1:0];
        default: ;
      endcase
    end
  end

  // Products of register values, settled long before any word reaches the scaling stage.
  logic [MW-1:0]   pbsr_q;
  logic [MW-1:0]   basr_q;
  logic [BLKW-1:0] bsms_q;

  always_ff @(posedge clk_i) begin
    pbsr_q <= MW'(pb_q) * MW'(sr_q);
    basr_q <= MW'(ba_q) * MW'(sr_q);
    bsms_q <= BLKW'(bs_q) * BLKW'(auc_pkg::MS_PER_S);
  end

  // Pipeline enable: everything moves unless the parking register is full.
  logic c_valid;
  logic out_valid_q;
  logic sk_valid_q;
  logic en;

  assign en              = !sk_valid_q;
  assign s_axis_tready_o = en;

  // Entry decode: codec block size numerator and divisor in the source unit.
  auc_pkg::unit_e  in_src;
  auc_pkg::unit_e  in_dst;
  logic [W-1:0]    in_amt;
  logic            in_codec;
  logic [BLKW-1:0] in_anum;
  logic [SRW-1:0]  in_adiv;
  auc_pkg::ctl_t   in_ctl;

  assign in_src   = auc_pkg::unit_e'(s_axis_tdata_i[1:0]);
  assign in_dst   = auc_pkg::unit_e'(s_axis_tdata_i[3:2]);
  assign in_amt   = s_axis_tdata_i[W+3:4];
  assign in_codec = (mode_q == auc_pkg::MODE_CODEC);

  always_comb begin
    in_anum = BLKW'(1);
    in_adiv = SRW'(1);
    if (in_codec) begin
      unique case (in_src)
        auc_pkg::U_MS: begin
          in_anum = BLKW'(bs_q) * BLKW'(auc_pkg::MS_PER_S);
          in_adiv = sr_q;
        end
        auc_pkg::U_SMP: in_anum = BLKW'(bs_q);
        auc_pkg::U_BYT: in_anum = BLKW'(pb_q);
        auc_pkg::U_PKT: in_anum = BLKW'(1);
        default:        in_anum = BLKW'(1);
      endcase
    end
    in_ctl.src = in_src;
    in_ctl.dst = in_dst;
    in_ctl.err = in_codec && (in_src == auc_pkg::U_MS) && (sr_q == '0);
  end

  // Entry register.
  logic            e_valid_q;
  auc_pkg::ctl_t   e_ctl_q;
  logic [W-1:0]    e_n_q;
  logic [BLKW-1:0] e_anum_q;
  logic [SRW-1:0]  e_adiv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_ctl_q  <= in_ctl;
      e_n_q    <= in_amt;
      e_anum_q <= in_anum;
      e_adiv_q <= in_adiv;
    end
  end

  // Chain A: codec block size, floored.
  logic            a_valid;
  logic [BLKW-1:0] a_blk;
  logic [CTLW+W-1:0] a_side;

  auc_div_chain #(
    .NW(BLKW),
    .DW(SRW),
    .SW(CTLW + W)
  ) u_blk_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(e_valid_q),
    .rem_i  ('0),
    .num_i  (e_anum_q),
    .div_i  (e_adiv_q),
    .side_i ({e_ctl_q, e_n_q}),
    .valid_o(a_valid),
    .rem_o  (),
    .num_o  (),
    .quo_o  (a_blk),
    .div_o  (),
    .side_o (a_side)
  );

  // A zero block size in codec mode is an error.
  auc_pkg::ctl_t a_ctl;
  auc_pkg::ctl_t a_ctl_chk;
  logic [W-1:0]  a_n;

  assign a_ctl = a_side[W +: CTLW];
  assign a_n   = a_side[W-1:0];

  always_comb begin
    a_ctl_chk     = a_ctl;
    a_ctl_chk.err = a_ctl.err || ((mode_q == auc_pkg::MODE_CODEC) && (a_blk == '0));
  end

  // Chain B: remainder of the amount over one block, for rounding up.
  logic            b_valid;
  logic [BLKW-1:0] b_rem;
  logic [W-1:0]    b_num;
  logic [BLKW-1:0] b_blk;
  logic [CTLW-1:0] b_side;

  auc_div_chain #(
    .NW(W),
    .DW(BLKW),
    .SW(CTLW)
  ) u_round_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(a_valid),
    .rem_i  ('0),
    .num_i  (a_n),
    .div_i  (a_blk),
    .side_i (a_ctl_chk),
    .valid_o(b_valid),
    .rem_o  (b_rem),
    .num_o  (b_num),
    .quo_o  (),
    .div_o  (b_blk),
    .side_o (b_side)
  );

  // Round up to a whole block and pick the scale factor and divisor.
  auc_pkg::ctl_t  b_ctl;
  logic [NRW-1:0] nr;
  logic [MW-1:0]  m_sel;
  logic [MW-1:0]  d_sel;
  logic [MW-1:0]  k_one;
  logic [MW-1:0]  k_ms;
  logic [MW-1:0]  k_sr;
  logic [MW-1:0]  k_ba;
  logic [MW-1:0]  k_pb;
  logic [MW-1:0]  k_bs;
  logic [MW-1:0]  k_bsms;

  assign b_ctl  = b_side;
  assign k_one  = MW'(1);
  assign k_ms   = MW'(auc_pkg::MS_PER_S);
  assign k_sr   = MW'(sr_q);
  assign k_ba   = MW'(ba_q);
  assign k_pb   = MW'(pb_q);
  assign k_bs   = MW'(bs_q);
  assign k_bsms = MW'(bsms_q);

  assign nr = (b_rem != '0) ? (NRW'(b_num) + NRW'(b_blk) - NRW'(b_rem)) : NRW'(b_num);

  always_comb begin
    m_sel = k_one;
    d_sel = k_one;
    if ((mode_q == auc_pkg::MODE_WAVE) && (b_ctl.src != b_ctl.dst) &&
        (b_ctl.src != auc_pkg::U_PKT) && (b_ctl.dst != auc_pkg::U_PKT)) begin
      unique case (b_ctl.dst)
        auc_pkg::U_MS: begin
          m_sel = k_ms;
          d_sel = (b_ctl.src == auc_pkg::U_SMP) ? k_sr : basr_q;
        end
        auc_pkg::U_SMP: begin
          m_sel = (b_ctl.src == auc_pkg::U_MS) ? k_sr : k_one;
          d_sel = (b_ctl.src == auc_pkg::U_MS) ? k_ms : k_ba;
        end
        auc_pkg::U_BYT: begin
          m_sel = (b_ctl.src == auc_pkg::U_MS) ? basr_q : k_ba;
          d_sel = (b_ctl.src == auc_pkg::U_MS) ? k_ms : k_one;
        end
        default: ;
      endcase
    end else if ((mode_q == auc_pkg::MODE_CODEC) && (b_ctl.src != b_ctl.dst)) begin
      unique case (b_ctl.dst)
        auc_pkg::U_MS: begin
          m_sel = (b_ctl.src == auc_pkg::U_SMP) ? k_ms : k_bsms;
          d_sel = (b_ctl.src == auc_pkg::U_BYT) ? pbsr_q : k_sr;
        end
        auc_pkg::U_SMP: begin
          if (b_ctl.src == auc_pkg::U_MS) begin
            m_sel = k_sr;
            d_sel = k_ms;
          end else begin
            m_sel = k_bs;
            d_sel = (b_ctl.src == auc_pkg::U_BYT) ? k_pb : k_one;
          end
        end
        auc_pkg::U_PKT: begin
          if (b_ctl.src == auc_pkg::U_MS) begin
            m_sel = k_sr;
            d_sel = k_bsms;
          end else begin
            m_sel = k_one;
            d_sel = (b_ctl.src == auc_pkg::U_SMP) ? k_bs : k_pb;
          end
        end
        auc_pkg::U_BYT: begin
          if (b_ctl.src == auc_pkg::U_MS) begin
            m_sel = pbsr_q;
            d_sel = k_bsms;
          end else begin
            m_sel = k_pb;
            d_sel = (b_ctl.src == auc_pkg::U_SMP) ? k_bs : k_one;
          end
        end
        default: ;
      endcase
    end
  end

  // Round-up register.
  logic           r_valid_q;
  logic [NRW-1:0] r_nr_q;
  logic [MW-1:0]  r_m_q;
  logic [MW-1:0]  r_d_q;
  logic           r_err_q;

  // First multiply stage: four partial products.
  logic                 p1_valid_q;
  logic [LH+MH-1:0]     p1_ll_q;
  logic [LH+MW-MH-1:0]  p1_lh_q;
  logic [NRW-LH+MH-1:0] p1_hl_q;
  logic [NRW-LH+MW-MH-1:0] p1_hh_q;
  logic [MW-1:0]        p1_d_q;
  logic                 p1_err_q;

  // Second multiply stage: the full product.
  logic          p2_valid_q;
  logic [PW-1:0] p2_prod_q;
  logic [MW-1:0] p2_d_q;
  logic          p2_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q  <= 1'b0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else if (en) begin
      r_valid_q  <= b_valid;
      p1_valid_q <= r_valid_q;
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_nr_q    <= nr;
      r_m_q     <= m_sel;
      r_d_q     <= d_sel;
      r_err_q   <= b_ctl.err;
      p1_ll_q   <= (LH+MH)'(r_nr_q[LH-1:0]) * (LH+MH)'(r_m_q[MH-1:0]);
      p1_lh_q   <= (LH+MW-MH)'(r_nr_q[LH-1:0]) * (LH+MW-MH)'(r_m_q[MW-1:MH]);
      p1_hl_q   <= (NRW-LH+MH)'(r_nr_q[NRW-1:LH]) * (NRW-LH+MH)'(r_m_q[MH-1:0]);
      p1_hh_q   <= (NRW-LH+MW-MH)'(r_nr_q[NRW-1:LH]) * (NRW-LH+MW-MH)'(r_m_q[MW-1:MH]);
      p1_d_q    <= r_d_q;
      p1_err_q  <= r_err_q;
      p2_prod_q <= PW'(p1_ll_q) + (PW'(p1_lh_q) << MH) + (PW'(p1_hl_q) << LH) +
                   (PW'(p1_hh_q) << (LH + MH));
      p2_d_q    <= p1_d_q;
      p2_err_q  <= p1_err_q;
    end
  end

  // The quotient exceeds the amount width exactly when the upper product part reaches
  // the divisor; otherwise that part is the starting remainder.
  logic [HW-1:0]   p2_hi;
  logic            p2_dz;
  auc_pkg::flags_t p2_flags;

  assign p2_hi        = p2_prod_q[PW-1:W];
  assign p2_dz        = (p2_d_q == '0);
  assign p2_flags.err = p2_err_q || p2_dz;
  assign p2_flags.ovf = !(p2_err_q || p2_dz) && (p2_hi >= HW'(p2_d_q));

  // Chain C: the final scaled quotient.
  logic [W-1:0]   c_quo;
  logic [FLW-1:0] c_side;

  auc_div_chain #(
    .NW(W),
    .DW(MW),
    .SW(FLW)
  ) u_scale_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(p2_valid_q),
    .rem_i  (p2_hi[MW-1:0]),
    .num_i  (p2_prod_q[W-1:0]),
    .div_i  (p2_d_q),
    .side_i (p2_flags),
    .valid_o(c_valid),
    .rem_o  (),
    .num_o  (),
    .quo_o  (c_quo),
    .div_o  (),
    .side_o (c_side)
  );

  // Output register and parking register: errors give zero, overflow saturates.
  auc_pkg::flags_t c_flags;
  logic [W-1:0]    c_res;
  logic            out_fire;
  logic            out_stall;
  logic            c_take;
  logic [W-1:0]    out_res_q;
  logic            out_ovf_q;
  logic            out_err_q;
  logic [W-1:0]    sk_res_q;
  logic            sk_ovf_q;
  logic            sk_err_q;

  assign c_flags   = c_side;
  assign c_res     = c_flags.err ? '0 : (c_flags.ovf ? '1 : c_quo);
  assign out_fire  = out_valid_q && m_axis_tready_i;
  assign out_stall = out_valid_q && !m_axis_tready_i;
  assign c_take    = en && c_valid;

  // A parked word moves to the output as soon as the output word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (sk_valid_q) begin
      if (out_fire) begin
        sk_valid_q <= 1'b0;
      end
    end else if (c_take) begin
      out_valid_q <= 1'b1;
      if (out_stall) begin
        sk_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (out_fire) begin
        out_res_q <= sk_res_q;
        out_ovf_q <= sk_ovf_q;
        out_err_q <= sk_err_q;
      end
    end else if (c_take) begin
      if (out_stall) begin
        sk_res_q <= c_res;
        sk_ovf_q <= c_flags.ovf;
        sk_err_q <= c_flags.err;
      end else begin
        out_res_q <= c_res;
        out_ovf_q <= c_flags.ovf;
        out_err_q <= c_flags.err;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TW'({out_err_q, out_ovf_q, out_res_q});

endmodule

FILE: design/auc_div_cell.sv
// One restoring division step: brings in one dividend bit and yields one quotient bit.
module auc_div_cell #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] quo_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] div_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_i, num_i[NW-1]};
  assign diff  = trial - {1'b0, div_i};
  assign ge    = (trial >= {1'b0, div_i});
  assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];

  // The valid bit is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // The dividend rotates, so it is whole again at the end of the chain.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      num_o  <= {num_i[NW-2:0], num_i[NW-1]};
      quo_o  <= {quo_i[NW-2:0], ge};
      div_o  <= div_i;
      side_o <= side_i;
    end
  end

endmodule

FILE: design/auc_div_chain.sv
// A row of division cells, one quotient bit per cell, taking a new word every cycle while enabled.
module auc_div_chain #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] div_o,
  output logic [SW-1:0] side_o
);

  logic          v_s    [NW+1];
  logic [DW-1:0] rem_s  [NW+1];
  logic [NW-1:0] num_s  [NW+1];
  logic [NW-1:0] quo_s  [NW+1];
  logic [DW-1:0] div_s  [NW+1];
  logic [SW-1:0] side_s [NW+1];

  // The first cell starts from the given remainder and an empty quotient.
  assign v_s[0]    = valid_i;
  assign rem_s[0]  = rem_i;
  assign num_s[0]  = num_i;
  assign quo_s[0]  = '0;
  assign div_s[0]  = div_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    auc_div_cell #(
      .NW(NW),
      .DW(DW),
      .SW(SW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(v_s[k]),
      .rem_i  (rem_s[k]),
      .num_i  (num_s[k]),
      .quo_i  (quo_s[k]),
      .div_i  (div_s[k]),
      .side_i (side_s[k]),
      .valid_o(v_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .num_o  (num_s[k+1]),
      .quo_o  (quo_s[k+1]),
      .div_o  (div_s[k+1]),
      .side_o (side_s[k+1])
    );
  end

  assign valid_o = v_s[NW];
  assign rem_o   = rem_s[NW];
  assign num_o   = num_s[NW];
  assign quo_o   = quo_s[NW];
  assign div_o   = div_s[NW];
  assign side_o  = side_s[NW];

endmodule

FILE: design/auc_checker.sv
// Port checker of the audio unit converter, bound to the top level.
module auc_checker #(
  parameter int AMOUNT_WIDTH = auc_pkg::AMOUNT_WIDTH_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [((AMOUNT_WIDTH+2+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int W = AMOUNT_WIDTH;

  logic [W-1:0] conv;
  logic         ovf;
  logic         err;

  assign conv = m_axis_tdata_o[W-1:0];
  assign ovf  = m_axis_tdata_o[W];
  assign err  = m_axis_tdata_o[W+1];

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  // A word never carries both flags.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(ovf && err))
    else $error("overflow and divide error both set");

  // An overflowed word is saturated.
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ovf |-> (conv == {W{1'b1}}))
    else $error("overflow without saturation");

  // A divide error gives zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && err |-> (conv == '0))
    else $error("divide error with nonzero result");

endmodule

bind audio_unit_converter auc_checker #(.AMOUNT_WIDTH(AMOUNT_WIDTH)) u_auc_checker (.*);
